@@ rtl/core/sha_pkg.sv @@
// sha_pkg: shared constants, types and round functions of the sha-256 byte hasher
// depends on nothing
package sha_pkg;

  localparam int unsigned BlkBytes  = 64;
  localparam int unsigned PadOffset = 56;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned CntW      = 61;

  // command from front to back: one byte, one finish marker, or both
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_of_message;
  } cmd_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } res_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[r];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/core/sha_if.sv @@
// sha_if: valid/ready channel carrying one word of a generic payload
// depends on nothing
interface sha_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/sha256_byte_hasher_core.sv @@
// channel   dir  payload                                  handshake
// in_       in   data_byte, has_byte, last_of_message     in_valid / in_ready
// out_      out  digest_word, word_index, last_word       out_valid / out_ready
// a byte is taken by the back end while idle; a full block then runs the
// 64 rounds of the single round unit and the hash update, taking no bytes
// a message end adds padding loads (up to 72), one or two blocks, then 8 words
// synchronous active-low reset restores the initial hash and a zero count
// a four-entry command queue lets input words arrive while rounds run
// top level: sha256 byte hasher, depends on sha_pkg, sha_if, sha_front, sha_back
module sha256_byte_hasher_core (
  input  logic clk,
  input  logic rst_n,
  sha_if.sink   in_ch,
  sha_if.source out_ch
);
  import sha_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_cmd;

  sha_front u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_cmd (in_ch.payload),
    .q_valid, .q_ready, .q_cmd
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_res (out_ch.payload)
  );
endmodule

@@ rtl/core/sha_front.sv @@
// sha_front: accepts input words and queues byte / finish commands
// depends on sha_pkg
module sha_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sha_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output sha_pkg::cmd_t q_cmd
);
  import sha_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t            mem_r [QDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  logic            push, pop;

  // words with neither byte nor end do nothing, drop them
  assign in_ready = (cnt_r != (PtrW+1)'(QDepth));
  assign push     = in_valid && in_ready && (in_cmd.has_byte || in_cmd.last_of_message);
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = mem_r[rp_r];
  assign pop      = q_valid && q_ready;

  // command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_cmd;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(QDepth)) else $error("queue overfilled");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (PtrW+1)'(QDepth)) |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0)) else $error("pop from empty queue");
endmodule

@@ rtl/core/sha_back.sv @@
// sha_back: block buffer, padding sequencer, 64-round compression and digest output
// depends on sha_pkg
module sha_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  sha_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output sha_pkg::res_t out_res
);
  import sha_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PAD  = 5'b00010,
    S_RND  = 5'b00100,
    S_ADD  = 5'b01000,
    S_OUT  = 5'b10000
  } st_t;

  st_t              st_r, st_nxt;
  logic [31:0]      h_r [8];
  logic [31:0]      v_r [8];
  logic [31:0]      w_r [16];
  logic [CntW-1:0]  cnt_r;
  logic [CntW-1:0]  len_r;
  logic             pend_r;   // message end taken, digest not yet fully output
  logic             fin_r;    // 0x80 marker already loaded
  logic             xblk_r;   // marker landed in the length slot before its last byte, zero-fill one more block
  logic             lend_r;   // length field loaded, digest follows this block
  logic [5:0]       rnd_r;
  logic [2:0]       oidx_r;
  logic             ovalid_r;
  logic [31:0]      odata_r;
  logic [2:0]       oword_r;

  logic             take;
  logic             pad_ld;
  logic             ld;
  logic             blk_end;
  logic             out_load;
  logic [7:0]       ld_byte;
  logic [5:0]       pos;
  logic [7:0]       pad_byte;
  logic [63:0]      bits;
  logic [31:0]      wn, s0, s1, e1, ch, e0, maj, t1, t2;

  assign pos  = cnt_r[5:0];
  assign bits = {len_r, 3'b000};

  // padding byte for the current offset
  always_comb begin
    priority if (!fin_r) pad_byte = 8'h80;
    else if (xblk_r || pos < 6'(PadOffset)) pad_byte = 8'h00;
    else pad_byte = bits[{~pos[2:0], 3'b000} +: 8];
  end

  assign q_ready  = (st_r == S_IDLE);
  assign take     = q_valid && q_ready;
  assign pad_ld   = (st_r == S_PAD);
  assign ld       = (take && q_cmd.has_byte) || pad_ld;
  assign ld_byte  = pad_ld ? pad_byte : q_cmd.data_byte;
  assign blk_end  = ld && (pos == 6'(BlkBytes - 1));
  assign out_load = (st_r == S_OUT) && (!ovalid_r || out_ready);

  // schedule: w_r[0] is the current round word
  assign s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wn = w_r[0] + s0 + w_r[9] + s1;

  assign e1  = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1  = v_r[7] + e1 + ch + round_k(rnd_r) + w_r[0];
  assign e0  = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2  = e0 + maj;

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (blk_end) st_nxt = S_RND;
        else if (take && q_cmd.last_of_message) st_nxt = S_PAD;
      end
      S_PAD: begin
        if (blk_end) st_nxt = S_RND;
      end
      S_RND: begin
        if (rnd_r == 6'd63) st_nxt = S_ADD;
      end
      S_ADD: begin
        if (lend_r) st_nxt = S_OUT;
        else if (pend_r) st_nxt = S_PAD;
        else st_nxt = S_IDLE;
      end
      S_OUT: begin
        if (out_load && oidx_r == 3'd7) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      cnt_r    <= '0;
      len_r    <= '0;
      pend_r   <= 1'b0;
      fin_r    <= 1'b0;
      xblk_r   <= 1'b0;
      lend_r   <= 1'b0;
      rnd_r    <= '0;
      oidx_r   <= '0;
      ovalid_r <= 1'b0;
      odata_r  <= '0;
      oword_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      st_r <= st_nxt;

      if (ld) cnt_r <= cnt_r + 1'b1;

      // message end: remember the length including its own byte
      if (take && q_cmd.last_of_message) begin
        pend_r <= 1'b1;
        len_r  <= cnt_r + CntW'(q_cmd.has_byte);
      end

      // padding progress flags
      if (pad_ld) begin
        if (!fin_r) begin
          fin_r  <= 1'b1;
          xblk_r <= (pos >= 6'(PadOffset)) && (pos != 6'(BlkBytes - 1));
        end else if (pos == 6'(BlkBytes - 1)) begin
          xblk_r <= 1'b0;
          lend_r <= !xblk_r;
        end
      end

      if (st_r == S_RND) rnd_r <= rnd_r + 1'b1;

      // fold round result into hash
      if (st_r == S_ADD) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end

      // digest output register
      if (out_load) begin
        ovalid_r <= 1'b1;
        odata_r  <= h_r[oidx_r];
        oword_r  <= oidx_r;
        oidx_r   <= oidx_r + 1'b1;
        if (oidx_r == 3'd7) begin
          for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
          cnt_r  <= '0;
          pend_r <= 1'b0;
          fin_r  <= 1'b0;
          lend_r <= 1'b0;
        end
      end else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  // byte loads build big-endian words into the schedule; rounds roll it
  always_ff @(posedge clk) begin
    if (ld) begin
      if (pos[1:0] == 2'd0) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= {24'h000000, ld_byte};
      end else begin
        w_r[15] <= {w_r[15][23:0], ld_byte};
      end
    end else if (st_r == S_RND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
    end
    if (st_r != S_RND) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign out_valid           = ovalid_r;
  assign out_res.digest_word = odata_r;
  assign out_res.word_index  = oword_r;
  assign out_res.last_word   = (oword_r == 3'd7);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ready) |=> (ovalid_r && $stable(odata_r) && $stable(oword_r)))
    else $error("result changed in stall");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !q_ready) else $error("command taken while busy");
  a_rnd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_RND) |-> (rnd_r == '0)) else $error("round counter not cleared");
  a_st_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r)) else $error("state not one-hot");
endmodule
